// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// No dependencies; every macro checks on the rising clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/lpic_pkg.sv -----
// Package for the length-prefixed integer codec: widths, codes and types.
// Used by the encoder, decoder, top level and checker; depends on nothing.
package lpic_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int VAL_W          = 32;
  localparam int CODE_W         = 44;
  localparam int LEN_W          = 6;
  localparam int ZC_W           = 3;
  localparam logic [ZC_W-1:0] MAX_ZEROS = 3'd5;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_CODE  = 1'b0,
    KIND_VALUE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_ZEROS = 3'b001,
    PH_LEN   = 3'b010,
    PH_VAL   = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [CODE_W-1:0]  code_bits;
    logic [LEN_W-1:0]   code_length;
    logic [VAL_W-1:0]   decoded_value;
    status_t            status;
  } result_t;

endpackage

// ----- hdl/lpic_enc.sv -----
// Combinational encoder: bit length search and codeword assembly for one value.
// Depends on lpic_pkg.
module lpic_enc #(
  parameter int VALUE_BITS = lpic_pkg::VALUE_BITS_DEF
) (
  input  logic [lpic_pkg::VAL_W-1:0] value,
  output lpic_pkg::result_t          res
);

  logic [VALUE_BITS-1:0]        v;
  logic [lpic_pkg::LEN_W-1:0]   n;
  logic [2:0]                   b;
  logic [lpic_pkg::LEN_W:0]     top_pos;
  logic [lpic_pkg::CODE_W-1:0]  code;

  assign v = value[VALUE_BITS-1:0];

  always_comb begin
    n = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (v[i]) begin
        n = lpic_pkg::LEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    b = '0;
    for (int j = 0; j < lpic_pkg::LEN_W; j++) begin
      if (n[j]) begin
        b = 3'(j + 1);
      end
    end
  end

  assign top_pos = {4'b0000, b} + {1'b0, n};
  assign code = (lpic_pkg::CODE_W'(1) << top_pos)
              | (lpic_pkg::CODE_W'(n) << n)
              | lpic_pkg::CODE_W'(v);

  always_comb begin
    res = '0;
    res.kind = lpic_pkg::KIND_CODE;
    if (v == '0) begin
      res.status = lpic_pkg::ST_ZERO;
    end else begin
      res.status      = lpic_pkg::ST_OK;
      res.code_bits   = code;
      res.code_length = lpic_pkg::LEN_W'({2'b00, b, 1'b0} + n);
    end
  end

endmodule

// ----- hdl/lpic_dec.sv -----
// Decoder phase machine: takes one code bit per step and reports finished values and malformed-stream flags.
// Depends on lpic_pkg.
module lpic_dec #(
  parameter int VALUE_BITS = lpic_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              bit_in,
  output logic              res_valid,
  output lpic_pkg::result_t res
);

  lpic_pkg::phase_t              phase_r, phase_nxt;
  logic [lpic_pkg::ZC_W-1:0]     zero_count_r, zero_count_nxt;
  logic [lpic_pkg::LEN_W-1:0]    bits_left_r, bits_left_nxt;
  logic [lpic_pkg::LEN_W-1:0]    length_acc_r, length_acc_nxt;
  logic [VALUE_BITS-1:0]         value_acc_r, value_acc_nxt;
  logic [lpic_pkg::LEN_W-1:0]    len_shift;
  logic [lpic_pkg::LEN_W-1:0]    bits_dec;
  logic [VALUE_BITS-1:0]         val_shift;

  assign len_shift = {length_acc_r[lpic_pkg::LEN_W-2:0], bit_in};
  assign bits_dec  = bits_left_r - lpic_pkg::LEN_W'(1);
  assign val_shift = {value_acc_r[VALUE_BITS-2:0], bit_in};

  always_comb begin
    phase_nxt      = phase_r;
    zero_count_nxt = zero_count_r;
    bits_left_nxt  = bits_left_r;
    length_acc_nxt = length_acc_r;
    value_acc_nxt  = value_acc_r;
    res_valid      = 1'b0;
    res            = '0;
    res.kind       = lpic_pkg::KIND_VALUE;
    res.status     = lpic_pkg::ST_OK;
    if (step) begin
      unique case (phase_r)
        lpic_pkg::PH_LEN: begin
          length_acc_nxt = len_shift;
          bits_left_nxt  = bits_dec;
          if (bits_dec == '0) begin
            if (len_shift > lpic_pkg::LEN_W'(VALUE_BITS) || len_shift == '0) begin
              res_valid      = 1'b1;
              res.status     = (len_shift == '0) ? lpic_pkg::ST_OK
                                                 : lpic_pkg::ST_MALFORMED;
              phase_nxt      = lpic_pkg::PH_ZEROS;
              zero_count_nxt = '0;
              bits_left_nxt  = '0;
              length_acc_nxt = '0;
              value_acc_nxt  = '0;
            end else begin
              bits_left_nxt = len_shift;
              value_acc_nxt = '0;
              phase_nxt     = lpic_pkg::PH_VAL;
            end
          end
        end
        lpic_pkg::PH_VAL: begin
          value_acc_nxt = val_shift;
          bits_left_nxt = bits_dec;
          if (bits_dec == '0) begin
            res_valid          = 1'b1;
            res.decoded_value  = lpic_pkg::VAL_W'(val_shift);
            phase_nxt          = lpic_pkg::PH_ZEROS;
            zero_count_nxt     = '0;
            bits_left_nxt      = '0;
            length_acc_nxt     = '0;
            value_acc_nxt      = '0;
          end
        end
        default: begin
          if (!bit_in) begin
            if (zero_count_r >= lpic_pkg::MAX_ZEROS) begin
              res_valid      = 1'b1;
              res.status     = lpic_pkg::ST_MALFORMED;
              zero_count_nxt = '0;
              bits_left_nxt  = '0;
              length_acc_nxt = '0;
              value_acc_nxt  = '0;
            end else begin
              zero_count_nxt = zero_count_r + lpic_pkg::ZC_W'(1);
            end
            phase_nxt = lpic_pkg::PH_ZEROS;
          end else begin
            bits_left_nxt  = lpic_pkg::LEN_W'(zero_count_r) + lpic_pkg::LEN_W'(1);
            length_acc_nxt = '0;
            zero_count_nxt = '0;
            phase_nxt      = lpic_pkg::PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lpic_pkg::PH_ZEROS;
      zero_count_r <= '0;
      bits_left_r  <= '0;
      length_acc_r <= '0;
      value_acc_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      zero_count_r <= zero_count_nxt;
      bits_left_r  <= bits_left_nxt;
      length_acc_r <= length_acc_nxt;
      value_acc_r  <= value_acc_nxt;
    end
  end

endmodule

// ----- hdl/length_prefixed_integer_codec_top.sv -----
// Length-prefixed integer codec, top level: input register, encoder or decoder step,
// result register. An accepted word is held in the input register and then in the result
// register. Throughput is one word per cycle for encode and decode words while the
// output is not stalled. A decode word that completes nothing gives no result.
// Synchronous reset returns the decoder to leading-zero counting and empties both
// registers; no clearing pass is needed. Depends on lpic_pkg, lpic_enc, lpic_dec.
module length_prefixed_integer_codec_top #(
  parameter int VALUE_BITS = lpic_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [lpic_pkg::VAL_W-1:0]  in_value,
  input  logic                        in_bit_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [lpic_pkg::CODE_W-1:0] out_code_bits,
  output logic [lpic_pkg::LEN_W-1:0]  out_code_length,
  output logic [lpic_pkg::VAL_W-1:0]  out_decoded_value,
  output logic [1:0]                  out_status
);

  logic                        s1_valid_r, s1_valid_nxt;
  lpic_pkg::op_t               op_r;
  logic [lpic_pkg::VAL_W-1:0]  value_r;
  logic                        bit_r;
  logic                        out_valid_r, out_valid_nxt;
  lpic_pkg::result_t           out_res_r;
  lpic_pkg::result_t           enc_res;
  lpic_pkg::result_t           dec_res;
  logic                        dec_valid;
  logic                        adv;
  logic                        dec_step;
  logic                        in_acc;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign dec_step = adv && (op_r == lpic_pkg::OP_DECODE);

  lpic_enc #(
    .VALUE_BITS(VALUE_BITS)
  ) u_enc (
    .value(value_r),
    .res  (enc_res)
  );

  lpic_dec #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (dec_step),
    .bit_in   (bit_r),
    .res_valid(dec_valid),
    .res      (dec_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (adv) begin
      out_valid_nxt = (op_r == lpic_pkg::OP_ENCODE) || dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= lpic_pkg::op_t'(in_operation);
      value_r <= in_value;
      bit_r   <= in_bit_in;
    end
    if (adv) begin
      out_res_r <= (op_r == lpic_pkg::OP_ENCODE) ? enc_res : dec_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_res_r.kind;
  assign out_code_bits     = out_res_r.code_bits;
  assign out_code_length   = out_res_r.code_length;
  assign out_decoded_value = out_res_r.decoded_value;
  assign out_status        = out_res_r.status;

endmodule

// ----- hdl/lpic_checker.sv -----
// Port-level checker for the codec top level, attached by the bind at the end.
// Depends on lpic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpic_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_kind,
  input logic [lpic_pkg::CODE_W-1:0] out_code_bits,
  input logic [lpic_pkg::LEN_W-1:0]  out_code_length,
  input logic [lpic_pkg::VAL_W-1:0]  out_decoded_value,
  input logic [1:0]                  out_status
);

  logic out_held;
  logic dec_word;
  logic enc_ok;

  assign out_held = out_valid && out_stall;
  assign dec_word = out_valid && out_kind == lpic_pkg::KIND_VALUE;
  assign enc_ok   = out_valid && out_kind == lpic_pkg::KIND_CODE
                    && out_status == lpic_pkg::ST_OK;

  `CHK_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_code_bits) && $stable(out_decoded_value) && $stable(out_status))
  `CHK_SAME(a_dec_no_code, clk, rst_n, dec_word, out_code_bits == '0 && out_code_length == '0 && out_status != lpic_pkg::ST_ZERO)
  `CHK_SAME(a_enc_len, clk, rst_n, enc_ok, out_code_length >= 6'd3 && out_code_length <= 6'd44 && out_decoded_value == '0)
  `CHK_SAME(a_zero_flag, clk, rst_n, out_valid && out_status == lpic_pkg::ST_ZERO, out_kind == lpic_pkg::KIND_CODE && out_code_length == '0 && out_code_bits == '0)
  `CHK_SAME(a_bad_len, clk, rst_n, out_valid && out_status == lpic_pkg::ST_MALFORMED, out_kind == lpic_pkg::KIND_VALUE && out_decoded_value == '0)

endmodule

bind length_prefixed_integer_codec_top lpic_checker u_lpic_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_integer_codec_top: encode and decode words
// are predicted by a scoreboard class and compared field by field with each result word.
// Depends on lpic_pkg and the codec RTL only.
module tb;
  import lpic_pkg::*;

  localparam int ITEMS = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [VAL_W-1:0] VALUE_MASK = VAL_W'((64'd1 << VALUE_BITS_DEF) - 64'd1);

  class codec_tracker;
    result_t expected_words[$];
    int unsigned mismatches;
    int unsigned encodes;
    int unsigned values;
    int unsigned flags;
    phase_t phase;
    logic [ZC_W-1:0] zero_count;
    logic [LEN_W-1:0] bits_left;
    logic [LEN_W-1:0] length_acc;
    logic [VAL_W-1:0] value_acc;

    function new();
      restart();
    endfunction

    function void restart();
      phase = PH_ZEROS;
      zero_count = '0;
      bits_left = '0;
      length_acc = '0;
      value_acc = '0;
    endfunction

    function bit decoder_idle();
      return phase == PH_ZEROS && zero_count == 0;
    endfunction

    static function int unsigned bit_count(logic [63:0] x);
      int unsigned n;
      n = 0;
      while (x != 0) begin
        n++;
        x = x >> 1;
      end
      return n;
    endfunction

    // The codeword is right aligned; its B-1 leading zeros are implied by len.
    static function logic [CODE_W-1:0] pack_codeword(logic [VAL_W-1:0] v,
                                                     output int unsigned len);
      int unsigned n;
      int unsigned b;
      logic [CODE_W-1:0] word;
      n = bit_count(v);
      b = bit_count(n);
      word = CODE_W'(1);
      word = (word << b) | CODE_W'(n);
      word = (word << n) | CODE_W'(v);
      len = 2 * b + n;
      return word;
    endfunction

    function void note_word(op_t op, logic [VAL_W-1:0] value, logic bit_in);
      result_t r;
      int unsigned len;
      logic [VAL_W-1:0] v;
      bit emit;
      r = '0;
      emit = 1'b0;
      if (op == OP_ENCODE) begin
        v = value & VALUE_MASK;
        r.kind = KIND_CODE;
        if (v == 0) begin
          r.status = ST_ZERO;
        end else begin
          r.code_bits = pack_codeword(v, len);
          r.code_length = LEN_W'(len);
          r.status = ST_OK;
        end
        expected_words.push_back(r);
        encodes++;
        return;
      end
      r.kind = KIND_VALUE;
      case (phase)
        PH_LEN: begin
          length_acc = {length_acc[LEN_W-2:0], bit_in};
          bits_left = bits_left - 1'b1;
          if (bits_left == 0) begin
            if (length_acc > VALUE_BITS_DEF) begin
              restart();
              r.status = ST_MALFORMED;
              emit = 1'b1;
            end else if (length_acc == 0) begin
              restart();
              r.status = ST_OK;
              emit = 1'b1;
            end else begin
              bits_left = length_acc;
              value_acc = '0;
              phase = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          value_acc = {value_acc[VAL_W-2:0], bit_in};
          bits_left = bits_left - 1'b1;
          if (bits_left == 0) begin
            r.decoded_value = value_acc;
            r.status = ST_OK;
            restart();
            emit = 1'b1;
          end
        end
        default: begin
          if (bit_in == 1'b0) begin
            if (zero_count >= MAX_ZEROS) begin
              restart();
              r.status = ST_MALFORMED;
              emit = 1'b1;
            end else begin
              zero_count = zero_count + 1'b1;
              phase = PH_ZEROS;
            end
          end else begin
            bits_left = LEN_W'(zero_count) + 1'b1;
            length_acc = '0;
            zero_count = '0;
            phase = PH_LEN;
          end
        end
      endcase
      if (emit) begin
        expected_words.push_back(r);
        if (r.status == ST_MALFORMED) begin
          flags++;
        end else begin
          values++;
        end
      end
    endfunction

    function void check_word(logic kind, logic [CODE_W-1:0] code_bits,
                             logic [LEN_W-1:0] code_length,
                             logic [VAL_W-1:0] decoded_value, logic [1:0] status);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (kind !== want.kind) begin
        $error("kind expected %0d actual %0d", want.kind, kind);
        mismatches++;
      end
      if (code_bits !== want.code_bits) begin
        $error("code_bits expected 'h%h actual 'h%h", want.code_bits, code_bits);
        mismatches++;
      end
      if (code_length !== want.code_length) begin
        $error("code_length expected %0d actual %0d", want.code_length, code_length);
        mismatches++;
      end
      if (decoded_value !== want.decoded_value) begin
        $error("decoded_value expected 'h%h actual 'h%h", want.decoded_value, decoded_value);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic [VAL_W-1:0] in_value;
  logic in_bit_in;
  logic out_valid;
  logic out_stall;
  logic out_kind;
  logic [CODE_W-1:0] out_code_bits;
  logic [LEN_W-1:0] out_code_length;
  logic [VAL_W-1:0] out_decoded_value;
  logic [1:0] out_status;

  logic jitter_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  codec_tracker tracker = new();
  codec_tracker stim_view = new();

  length_prefixed_integer_codec_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_bit_in        (in_bit_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_code_bits    (out_code_bits),
    .out_code_length  (out_code_length),
    .out_decoded_value(out_decoded_value),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_value = '0;
    in_bit_in = 1'b0;
    out_stall = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= jitter_on && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_word(out_kind, out_code_bits, out_code_length, out_decoded_value,
                           out_status);
      end
      if (in_valid && !in_stall) begin
        tracker.note_word(op_t'(in_operation), in_value, in_bit_in);
      end
    end
  end

  function automatic logic [VAL_W-1:0] random_value();
    return $urandom >> $urandom_range(0, VAL_W - 1);
  endfunction

  task automatic send_word(op_t op, logic [VAL_W-1:0] value, logic bit_in);
    while (jitter_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= value;
    in_bit_in <= bit_in;
    do @(posedge clk); while (in_stall);
    stim_view.note_word(op, value, bit_in);
    items_sent++;
  endtask

  // Sends pattern's low count bits MSB first as decode words, mixing in encode words.
  task automatic send_bits(logic [63:0] pattern, int unsigned count, int unsigned mix_pct);
    int unsigned i;
    for (i = count; i > 0; i--) begin
      if ($urandom_range(0, 99) < mix_pct) begin
        send_word(OP_ENCODE, random_value(), 1'($urandom_range(0, 1)));
      end
      send_word(OP_DECODE, $urandom, pattern[i-1]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] word;
    logic [VAL_W-1:0] v;
    int unsigned len;
    int unsigned sel;
    bit drained_mid;
    drained_mid = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_ENCODE, 32'd0, 1'b1);
    send_word(OP_ENCODE, 32'd1, 1'b0);
    send_word(OP_ENCODE, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_ENCODE, 32'h8000_0000, 1'b0);
    send_word(OP_ENCODE, 32'h5555_5555, 1'b1);
    send_bits(64'b111, 3, 0);
    send_bits(64'b10, 2, 0);
    send_bits(64'b0, 6, 0);
    send_bits(64'b0000_0110_0001, 12, 0);
    wait_drained();

    while (items_sent < ITEMS) begin
      jitter_on = !(items_sent >= 600 && items_sent < 850);
      if (!drained_mid && items_sent >= 1000) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      sel = $urandom_range(0, 99);
      v = random_value();
      if (v == 0) begin
        v = 32'd1;
      end
      word = codec_tracker::pack_codeword(v, len);
      if (sel < 70) begin
        while (!stim_view.decoder_idle()) begin
          send_word(OP_DECODE, $urandom, 1'($urandom_range(0, 1)));
        end
        send_bits(64'(word), len, 10);
      end else if (sel < 80) begin
        sel = $urandom_range(1, len - 1);
        send_bits(64'(word >> (len - sel)), sel, 10);
      end else if (sel < 90) begin
        send_bits({$urandom, $urandom}, $urandom_range(1, 8), 0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(OP_ENCODE, ($urandom_range(0, 7) == 0) ? 32'd0 : random_value(),
                    1'($urandom_range(0, 1)));
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d codeword results, %0d decoded values and %0d malformed-stream flags",
             tracker.encodes, tracker.values, tracker.flags);
    $display("from %0d input words, with random idles and stalls and one quiet stretch.",
             items_sent);
    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lpic_pkg.sv
hdl/lpic_enc.sv
hdl/lpic_dec.sv
hdl/length_prefixed_integer_codec_top.sv
hdl/lpic_checker.sv
tb/tb.sv
